[design/cla_pkg.sv]
`timescale 1ns / 1ps

package cla_pkg;

    // Carried parent tags and compare keys (commit tag plus parents)
    localparam int CARRIED    = 4;
    localparam int KEYS       = CARRIED + 1;
    localparam int TAG_IN_W   = 64;
    localparam int CNT_W      = 3;
    localparam int LANE_OUT_W = 6;
    localparam int MASK_W     = 32;
    localparam int SEL_W      = $clog2(CARRIED);

    // Per-lane write-back control
    typedef struct packed {
        logic             set;
        logic             clr;
        logic [SEL_W-1:0] sel;
    } t_lane_ctl;

endpackage

[design/cla_if.sv]
`timescale 1ns / 1ps

interface cla_req_if import cla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TAG_IN_W-1:0] commit_id;
    logic [CNT_W-1:0]    parent_count;
    logic [TAG_IN_W-1:0] parent_id_0;
    logic [TAG_IN_W-1:0] parent_id_1;
    logic [TAG_IN_W-1:0] parent_id_2;
    logic [TAG_IN_W-1:0] parent_id_3;

    modport source (output valid, commit_id, parent_count, parent_id_0, parent_id_1,
                    parent_id_2, parent_id_3, input ready);
    modport sink   (input valid, commit_id, parent_count, parent_id_0, parent_id_1,
                    parent_id_2, parent_id_3, output ready);
endinterface

interface cla_rsp_if import cla_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LANE_OUT_W-1:0] node_lane;
    logic [LANE_OUT_W-1:0] parent_lane_0;
    logic [LANE_OUT_W-1:0] parent_lane_1;
    logic [LANE_OUT_W-1:0] parent_lane_2;
    logic [LANE_OUT_W-1:0] parent_lane_3;
    logic [MASK_W-1:0]     active_mask;
    logic                  lane_overflow;

    modport source (output valid, node_lane, parent_lane_0, parent_lane_1, parent_lane_2,
                    parent_lane_3, active_mask, lane_overflow, input ready);
    modport sink   (input valid, node_lane, parent_lane_0, parent_lane_1, parent_lane_2,
                    parent_lane_3, active_mask, lane_overflow, output ready);
endinterface

[design/cla_lane.sv]
`timescale 1ns / 1ps

// One lane: stored tag, busy flag, compare against all keys of a request.
module cla_lane import cla_pkg::*; #(
    parameter int TAG_WIDTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cap,
    input  logic [KEYS-1:0][TAG_WIDTH-1:0]    i_key,
    input  t_lane_ctl                         i_ctl,
    input  logic [CARRIED-1:0][TAG_WIDTH-1:0] i_ptag,
    output logic [KEYS-1:0]                   o_hit,
    output logic                              o_busy
);

    logic [TAG_WIDTH-1:0] r_tag;
    logic                 r_busy;
    logic [KEYS-1:0]      r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.set) begin
            r_busy <= 1'b1;
        end else if (i_ctl.clr) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.set) begin
            r_tag <= i_ptag[i_ctl.sel];
        end
        if (i_cap) begin
            for (int k = 0; k < KEYS; k++) begin
                r_hit[k] <= r_busy && (r_tag == i_key[k]);
            end
        end
    end

    assign o_hit  = r_hit;
    assign o_busy = r_busy;

endmodule

[design/cla_merge.sv]
`timescale 1ns / 1ps

// Merges lane hits: priority picks, fresh-lane reservation, write-back control.
module cla_merge import cla_pkg::*; #(
    parameter int LANE_COUNT = 32,
    parameter int LW         = $clog2(LANE_COUNT + 1)
) (
    input  logic [LANE_COUNT-1:0][KEYS-1:0] i_hit,
    input  logic [LANE_COUNT-1:0]           i_busy,
    input  logic [CNT_W-1:0]                i_cnt,
    input  logic                            i_go,
    output logic [LW-1:0]                   o_node,
    output logic [CARRIED-1:0][LW-1:0]      o_plane,
    output logic                            o_ovf,
    output t_lane_ctl [LANE_COUNT-1:0]      o_ctl
);

    localparam logic [LW-1:0] NONE = LW'(LANE_COUNT);

    function automatic logic [LW-1:0] lowest(input logic [LANE_COUNT-1:0] v);
        logic [LW-1:0] r;
        r = NONE;
        for (int i = LANE_COUNT - 1; i >= 0; i--) begin
            if (v[i]) r = LW'(i);
        end
        return r;
    endfunction

    logic [KEYS-1:0][LANE_COUNT-1:0] col;
    logic [LANE_COUNT-1:0]           avail;

    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            for (int l = 0; l < LANE_COUNT; l++) begin
                col[k][l] = i_hit[l][k];
            end
        end
    end

    always_comb begin
        avail   = ~i_busy;
        o_ovf   = 1'b0;
        o_plane = {CARRIED{NONE}};
        if (|col[0]) begin
            o_node = lowest(col[0]);
        end else begin
            o_node = lowest(avail);
            avail  = avail & (avail - 1'b1);   // reserve lowest free lane
        end
        if (o_node == NONE) begin
            o_ovf = 1'b1;
        end else if (i_cnt != '0) begin
            o_plane[0] = (|col[1]) ? lowest(col[1]) : o_node;
            for (int i = 1; i < CARRIED; i++) begin
                if (CNT_W'(i) < i_cnt) begin
                    if (|col[i + 1]) begin
                        o_plane[i] = lowest(col[i + 1]);
                    end else begin
                        o_plane[i] = lowest(avail);
                        avail      = avail & (avail - 1'b1);
                    end
                    if (o_plane[i] == NONE) o_ovf = 1'b1;
                end
            end
        end
    end

    // later parent writes win
    always_comb begin
        for (int l = 0; l < LANE_COUNT; l++) begin
            o_ctl[l] = '0;
            if (i_go && !o_ovf) begin
                if (i_cnt == '0) begin
                    o_ctl[l].clr = (o_node == LW'(l));
                end else begin
                    if (o_node == LW'(l)) o_ctl[l].set = 1'b1;
                    for (int i = 1; i < CARRIED; i++) begin
                        if (CNT_W'(i) < i_cnt && o_plane[i] == LW'(l)) begin
                            o_ctl[l].set = 1'b1;
                            o_ctl[l].sel = SEL_W'(i);
                        end
                    end
                end
            end
        end
    end

endmodule

[design/commit_lane_allocator.sv]
`timescale 1ns / 1ps

// Timing: the lane compare is captured when a request is accepted; the pick and
//   write-back load the response register, held back while the last response waits.
// Requests: a new one is taken only after the pending one is picked, so the pick and
//   table write precede its compare; each commit depends on the updated lane table.
// Response held in an output register; a new request is taken while it waits.
// Reset (i_rst_n low, synchronous): all lanes free, pipeline and response empty.
// Lane tags hold no reset value; a tag is only compared while its lane is busy.
module commit_lane_allocator import cla_pkg::*; #(
    parameter int LANE_COUNT  = 32,
    parameter int MAX_PARENTS = 4,
    parameter int TAG_WIDTH   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cla_req_if.sink   i_req,
    cla_rsp_if.source o_rsp
);

    localparam int              LW   = $clog2(LANE_COUNT + 1);
    localparam logic [LW-1:0]   NONE = LW'(LANE_COUNT);
    localparam int              LIM  = (MAX_PARENTS < CARRIED) ? MAX_PARENTS : CARRIED;
    localparam int              PADW = (LANE_COUNT > MASK_W) ? LANE_COUNT : MASK_W;

    // request handshake
    logic acc;
    logic go;
    logic r_pend;
    logic r_ovalid;

    assign i_req.ready = !r_pend;
    assign acc         = i_req.valid && i_req.ready;
    // pick stage fires once the response register is free
    assign go          = r_pend && (!r_ovalid || o_rsp.ready);

    // compare keys from the request, tags trimmed to TAG_WIDTH
    logic [KEYS-1:0][TAG_WIDTH-1:0]    key;
    logic [CARRIED-1:0][TAG_WIDTH-1:0] r_ptag;
    logic [CNT_W-1:0]                  n_cnt;
    logic [CNT_W-1:0]                  r_cnt;

    assign key[0] = i_req.commit_id[TAG_WIDTH-1:0];
    assign key[1] = i_req.parent_id_0[TAG_WIDTH-1:0];
    assign key[2] = i_req.parent_id_1[TAG_WIDTH-1:0];
    assign key[3] = i_req.parent_id_2[TAG_WIDTH-1:0];
    assign key[4] = i_req.parent_id_3[TAG_WIDTH-1:0];

    // parent count saturates at the supported limit
    assign n_cnt = (i_req.parent_count > CNT_W'(LIM)) ? CNT_W'(LIM) : i_req.parent_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (acc) begin
            r_pend <= 1'b1;
        end else if (go) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cnt <= n_cnt;
            for (int i = 0; i < CARRIED; i++) begin
                r_ptag[i] <= key[i + 1];
            end
        end
    end

    // lane array: each lane compares every key in parallel
    logic [LANE_COUNT-1:0][KEYS-1:0] hit;
    logic [LANE_COUNT-1:0]           busy;
    t_lane_ctl [LANE_COUNT-1:0]      ctl;

    for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
        cla_lane #(
            .TAG_WIDTH (TAG_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cap   (acc),
            .i_key   (key),
            .i_ctl   (ctl[l]),
            .i_ptag  (r_ptag),
            .o_hit   (hit[l]),
            .o_busy  (busy[l])
        );
    end

    // merge: node/parent picks, fresh lane reservation, write-back
    logic [LW-1:0]              node;
    logic [CARRIED-1:0][LW-1:0] plane;
    logic                       ovf;

    cla_merge #(
        .LANE_COUNT (LANE_COUNT),
        .LW         (LW)
    ) u_merge (
        .i_hit   (hit),
        .i_busy  (busy),
        .i_cnt   (r_cnt),
        .i_go    (go),
        .o_node  (node),
        .o_plane (plane),
        .o_ovf   (ovf),
        .o_ctl   (ctl)
    );

    // active mask reflects the table before this update, plus the node lane
    logic [PADW-1:0]   busy_pad;
    logic [MASK_W-1:0] n_mask;

    assign busy_pad = PADW'(busy);

    always_comb begin
        for (int b = 0; b < MASK_W; b++) begin
            n_mask[b] = busy_pad[b] || ((b < LANE_COUNT) && (node == LW'(b)));
        end
    end

    // response register
    logic [LW-1:0]              r_node;
    logic [CARRIED-1:0][LW-1:0] r_plane;
    logic [MASK_W-1:0]          r_mask;
    logic                       r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (go) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_node  <= node;
            r_plane <= plane;
            r_mask  <= n_mask;
            r_ovf   <= ovf;
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.node_lane     = LANE_OUT_W'(r_node);
    assign o_rsp.parent_lane_0 = LANE_OUT_W'(r_plane[0]);
    assign o_rsp.parent_lane_1 = LANE_OUT_W'(r_plane[1]);
    assign o_rsp.parent_lane_2 = LANE_OUT_W'(r_plane[2]);
    assign o_rsp.parent_lane_3 = LANE_OUT_W'(r_plane[3]);
    assign o_rsp.active_mask   = r_mask;
    assign o_rsp.lane_overflow = r_ovf;

    // at most one lane freed per commit
    logic [LANE_COUNT-1:0] clr_vec;

    always_comb begin
        for (int l = 0; l < LANE_COUNT; l++) begin
            clr_vec[l] = ctl[l].clr;
        end
    end

    a_acc_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_pend)
        else $error("accepted request not pending");

    a_no_node_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_node == NONE) |-> r_ovf)
        else $error("missing node lane without overflow");

    a_one_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(clr_vec))
        else $error("more than one lane freed");

    a_go_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> (r_ovalid && !r_pend))
        else $error("pick did not load response");

endmodule
